// File: src/sep_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Event stream parser package
// Shared request and token types, token kinds, parser state and queue sizing.
// ----------------------------------------------------------------------------
package sep_pkg;

   typedef struct packed {
      logic       func;
      logic [7:0] stream_byte;
   } req_type;

   typedef struct packed {
      logic [2:0] token_kind;
      logic [7:0] token_byte;
      logic       last_of_run;
   } rsp_type;

   localparam logic [2:0] KIND_NAME_RESTART = 3'd0;
   localparam logic [2:0] KIND_NAME_BYTE    = 3'd1;
   localparam logic [2:0] KIND_SEPARATOR    = 3'd2;
   localparam logic [2:0] KIND_DATA_BYTE    = 3'd3;
   localparam logic [2:0] KIND_PUBLISH      = 3'd4;
   localparam logic [2:0] KIND_DROP         = 3'd5;
   localparam logic [2:0] KIND_ERROR        = 3'd6;

   localparam logic FUNC_BYTE = 1'b0;
   localparam logic FUNC_END  = 1'b1;

   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_COLON = 8'h3A;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_NUL   = 8'h00;

   localparam logic [3:0] MATCH_EMPTY = 4'd0;
   localparam logic [3:0] MATCH_E     = 4'd1;
   localparam logic [3:0] MATCH_EVENT = 4'd5;
   localparam logic [3:0] MATCH_D     = 4'd6;
   localparam logic [3:0] MATCH_DATA  = 4'd9;
   localparam logic [3:0] MATCH_NONE  = 4'd15;

   typedef enum logic [1:0] {
      PHASE_NAME,
      PHASE_VALUE,
      PHASE_COMMENT
   } phase_type;

   typedef enum logic [1:0] {
      TARGET_NONE,
      TARGET_EVENT,
      TARGET_DATA
   } target_type;

   typedef struct packed {
      logic       failed;
      logic       line_started;
      phase_type  phase;
      logic [3:0] match;
      target_type target;
      logic       skip_space;
      logic       cr_pending;
      logic       fields_seen;
      logic       data_seen;
   } state_type;

   typedef struct packed {
      logic [1:0] count;
      rsp_type    tok0;
      rsp_type    tok1;
   } push_type;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

endpackage

// File: src/sse_event_stream_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Server-sent events stream parser
// Frames a byte stream into lines and emits event name, data, publish,
// drop and error tokens.
//
//   Channel   Ports                        Direction   Moves
//   req       req_valid/ready, req_data    in          stream byte or end mark
//   rsp       rsp_valid/ready, rsp_data    out         one token
//
// One request is taken per cycle while the token queue has room; a request
// waits in the request register and its tokens go into the queue. The single
// token port sets the rate: sustained input is one request per token, at most one
// per cycle. A four-entry token queue lets new requests enter while tokens
// wait. Reset is synchronous and clears the parser state and the queue.
// A stalled token port fills the queue and then holds the request register.
// ----------------------------------------------------------------------------
module sse_event_stream_parser (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  sep_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output sep_pkg::rsp_type rsp_data
);
   import sep_pkg::*;

   logic     in_valid_ff;
   logic     in_valid_in;
   req_type  in_ff;
   logic     room;
   logic     process;
   logic     pop;
   push_type push;

   assign process   = in_valid_ff && room;
   assign req_ready = !in_valid_ff || process;
   assign pop       = rsp_valid && rsp_ready;

   always_comb begin
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
      end else if (process) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_ff <= req_data;
      end
   end

   sep_core u_core (
      .clock (clock),
      .reset (reset),
      .step  (process),
      .req   (in_ff),
      .push  (push)
   );

   sep_outq u_outq (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pop   (pop),
      .room  (room),
      .valid (rsp_valid),
      .head  (rsp_data)
   );

   // An error token always closes the tokens of its request.
   a_error_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.token_kind == KIND_ERROR |-> rsp_data.last_of_run)
      else $error("error token is not the last of its request");

   // Once an error has been delivered, only error tokens follow.
   a_error_sticky: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_data.token_kind == KIND_ERROR |=>
      !rsp_valid || rsp_data.token_kind == KIND_ERROR)
      else $error("non-error token after an error");

   // A data separator always carries a line feed.
   a_separator_byte: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.token_kind == KIND_SEPARATOR |->
      rsp_data.token_byte == CHAR_LF)
      else $error("separator token with wrong byte");

endmodule

// File: src/sep_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Event stream parser core
// Holds the line and event state and turns one request into up to two tokens.
// ----------------------------------------------------------------------------
module sep_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              step,
   input  sep_pkg::req_type  req,
   output sep_pkg::push_type push
);
   import sep_pkg::*;

   typedef struct packed {
      state_type  st;
      logic [1:0] n;
      rsp_type    r0;
      rsp_type    r1;
   } work_type;

   state_type state_ff;
   state_type state_in;
   work_type  w;

   function automatic work_type emit(work_type wi, logic [2:0] kind, logic [7:0] b);
      work_type wo;
      wo = wi;
      if (wi.n == 2'd0) begin
         wo.r0 = '{token_kind: kind, token_byte: b, last_of_run: 1'b0};
         wo.n  = 2'd1;
      end else if (wi.n == 2'd1) begin
         wo.r1 = '{token_kind: kind, token_byte: b, last_of_run: 1'b0};
         wo.n  = 2'd2;
      end
      return wo;
   endfunction

   function automatic state_type clear_line(state_type si);
      state_type so;
      so = si;
      so.line_started = 1'b0;
      so.phase        = PHASE_NAME;
      so.match        = MATCH_EMPTY;
      so.target       = TARGET_NONE;
      so.skip_space   = 1'b0;
      return so;
   endfunction

   function automatic work_type go_failed(work_type wi);
      work_type wo;
      wo = wi;
      wo.st = clear_line(wi.st);
      wo.st.cr_pending  = 1'b0;
      wo.st.fields_seen = 1'b0;
      wo.st.data_seen   = 1'b0;
      wo.st.failed      = 1'b1;
      wo = emit(wo, KIND_ERROR, CHAR_NUL);
      return wo;
   endfunction

   function automatic work_type publish(work_type wi);
      work_type wo;
      wo = wi;
      if (wi.st.fields_seen) begin
         wo = emit(wo, wi.st.data_seen ? KIND_PUBLISH : KIND_DROP, CHAR_NUL);
      end
      wo.st.fields_seen = 1'b0;
      wo.st.data_seen   = 1'b0;
      return wo;
   endfunction

   function automatic logic [3:0] advance_match(logic [3:0] m, logic [7:0] b);
      logic [7:0] want;
      logic [3:0] r;
      want = CHAR_NUL;
      r    = MATCH_NONE;
      unique case (m)
         4'd1:    want = "v";
         4'd2:    want = "e";
         4'd3:    want = "n";
         4'd4:    want = "t";
         4'd6:    want = "a";
         4'd7:    want = "t";
         4'd8:    want = "a";
         default: want = CHAR_NUL;
      endcase
      if (m == MATCH_EMPTY) begin
         r = (b == "e") ? MATCH_E : ((b == "d") ? MATCH_D : MATCH_NONE);
      end else if ((m >= 4'd1 && m <= 4'd4) || (m >= 4'd6 && m <= 4'd8)) begin
         r = (b == want) ? 4'(m + 4'd1) : MATCH_NONE;
      end
      return r;
   endfunction

   function automatic work_type resolve_field(work_type wi);
      work_type wo;
      wo = wi;
      if (wi.st.match == MATCH_EVENT) begin
         wo = emit(wo, KIND_NAME_RESTART, CHAR_NUL);
         wo.st.fields_seen = 1'b1;
         wo.st.target      = TARGET_EVENT;
      end else if (wi.st.match == MATCH_DATA) begin
         if (wi.st.data_seen) begin
            wo = emit(wo, KIND_SEPARATOR, CHAR_LF);
         end
         wo.st.data_seen   = 1'b1;
         wo.st.fields_seen = 1'b1;
         wo.st.target      = TARGET_DATA;
      end else begin
         wo.st.target = TARGET_NONE;
      end
      return wo;
   endfunction

   function automatic work_type take_byte(work_type wi, logic [7:0] b);
      work_type wo;
      logic     done;
      wo   = wi;
      done = 1'b0;
      if (wi.st.failed) begin
         done = 1'b1;
      end else if (b == CHAR_NUL &&
                   !(wi.st.line_started && wi.st.phase == PHASE_COMMENT)) begin
         wo   = go_failed(wo);
         done = 1'b1;
      end else if (!wi.st.line_started) begin
         wo.st.line_started = 1'b1;
         wo.st.match        = MATCH_EMPTY;
         wo.st.target       = TARGET_NONE;
         wo.st.skip_space   = 1'b0;
         if (b == CHAR_COLON) begin
            wo.st.phase = PHASE_COMMENT;
            done        = 1'b1;
         end else begin
            wo.st.phase = PHASE_NAME;
         end
      end
      if (!done) begin
         unique case (wo.st.phase)
            PHASE_NAME: begin
               if (b == CHAR_COLON) begin
                  wo = resolve_field(wo);
                  wo.st.phase      = PHASE_VALUE;
                  wo.st.skip_space = 1'b1;
               end else begin
                  wo.st.match = advance_match(wo.st.match, b);
               end
            end
            PHASE_VALUE: begin
               if (!(wo.st.skip_space && b == CHAR_SPACE)) begin
                  if (wo.st.target == TARGET_EVENT) begin
                     wo = emit(wo, KIND_NAME_BYTE, b);
                  end else if (wo.st.target == TARGET_DATA) begin
                     wo = emit(wo, KIND_DATA_BYTE, b);
                  end
               end
               wo.st.skip_space = 1'b0;
            end
            default: begin
            end
         endcase
      end
      return wo;
   endfunction

   function automatic work_type end_line(work_type wi);
      work_type wo;
      wo = wi;
      wo.st.cr_pending = 1'b0;
      if (!wi.st.line_started) begin
         wo = publish(wo);
      end else if (wi.st.phase == PHASE_NAME) begin
         wo = resolve_field(wo);
      end
      wo.st = clear_line(wo.st);
      return wo;
   endfunction

   always_comb begin
      w.st = state_ff;
      w.n  = 2'd0;
      w.r0 = '0;
      w.r1 = '0;
      if (state_ff.failed) begin
         w = emit(w, KIND_ERROR, CHAR_NUL);
      end else if (req.func == FUNC_END) begin
         if (state_ff.line_started || state_ff.cr_pending) begin
            w = go_failed(w);
         end else begin
            w = publish(w);
         end
      end else if (req.stream_byte == CHAR_LF) begin
         w = end_line(w);
      end else if (req.stream_byte == CHAR_CR) begin
         if (state_ff.cr_pending) begin
            w = take_byte(w, CHAR_CR);
         end
         w.st.cr_pending = 1'b1;
      end else begin
         if (state_ff.cr_pending) begin
            w.st.cr_pending = 1'b0;
            w = take_byte(w, CHAR_CR);
         end
         w = take_byte(w, req.stream_byte);
      end
      w.r0.last_of_run = (w.n == 2'd1);
      w.r1.last_of_run = (w.n == 2'd2);
   end

   always_comb begin
      state_in   = step ? w.st : state_ff;
      push.count = step ? w.n : 2'd0;
      push.tok0  = w.r0;
      push.tok1  = w.r1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: src/sep_outq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Event stream parser token queue
// Small register queue that takes up to two tokens a cycle and returns one.
// ----------------------------------------------------------------------------
module sep_outq (
   input  logic              clock,
   input  logic              reset,
   input  sep_pkg::push_type push,
   input  logic              pop,
   output logic              room,
   output logic              valid,
   output sep_pkg::rsp_type  head
);
   import sep_pkg::*;

   rsp_type                mem_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff;
   logic [QUEUE_PTR_W-1:0] wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff;
   logic [QUEUE_PTR_W-1:0] rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff;
   logic [QUEUE_CNT_W-1:0] count_in;
   logic [QUEUE_PTR_W-1:0] wr_next;

   assign valid   = (count_ff != '0);
   assign head    = mem_ff[rd_ptr_ff];
   assign room    = (count_ff <= QUEUE_CNT_W'(QUEUE_DEPTH - 2)) ||
                    ((count_ff == QUEUE_CNT_W'(QUEUE_DEPTH - 1)) && pop);
   assign wr_next = QUEUE_PTR_W'(wr_ptr_ff + QUEUE_PTR_W'(1));

   always_comb begin
      wr_ptr_in = QUEUE_PTR_W'(wr_ptr_ff + QUEUE_PTR_W'(push.count));
      rd_ptr_in = QUEUE_PTR_W'(rd_ptr_ff + QUEUE_PTR_W'(pop));
      count_in  = QUEUE_CNT_W'(count_ff + QUEUE_CNT_W'(push.count) - QUEUE_CNT_W'(pop));
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         mem_ff[wr_ptr_ff] <= push.tok0;
      end
      if (push.count == 2'd2) begin
         mem_ff[wr_next] <= push.tok1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule
